// ===== design/rwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwm_pkg
// Shared constants, types and compare helpers for the RGB window median filter.
// ----------------------------------------------------------------------------
package rwm_pkg;

    // window geometry
    localparam int RADIUS     = 1;
    localparam int WIN_SIDE   = 2 * RADIUS + 1;

    // image limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);

    // channel and register widths
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int CFG_W      = 11;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
    localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [CH_W-1:0] t_chan_val;

    // input item
    typedef struct packed {
        t_chan_val red_in;
        t_chan_val green_in;
        t_chan_val blue_in;
    } t_pix;

    // result item
    typedef struct packed {
        t_chan_val        red_median;
        t_chan_val        green_median;
        t_chan_val        blue_median;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } t_med;

    // position info that travels with an item
    typedef struct packed {
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
        logic             frame_last;
    } t_tag;

    // channel view of a pixel, index 2 is red
    typedef logic [NUM_CH-1:0][CH_W-1:0] t_chans;

    // one window column of one channel, sorted
    typedef struct packed {
        t_chan_val lo;
        t_chan_val mid;
        t_chan_val hi;
    } t_sort3;

    typedef t_sort3 [NUM_CH-1:0] t_col_sorted;

    // line store word: the two rows above the current one
    typedef struct packed {
        t_pix above1;
        t_pix above2;
    } t_ls_rd;

    // line store access
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        t_ls_rd           wr_data;
    } t_ls_req;

    function automatic t_chan_val min2(input t_chan_val a, input t_chan_val b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_chan_val max2(input t_chan_val a, input t_chan_val b);
        return (a < b) ? b : a;
    endfunction

    function automatic t_chan_val med3(input t_chan_val a, input t_chan_val b,
                                       input t_chan_val c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic t_sort3 sort3(input t_chan_val a, input t_chan_val b,
                                     input t_chan_val c);
        t_sort3 s;
        s.lo  = min2(min2(a, b), c);
        s.mid = med3(a, b, c);
        s.hi  = max2(max2(a, b), c);
        return s;
    endfunction

endpackage

// ===== design/rwm_pix_if.sv =====
// ----------------------------------------------------------------------------
// rwm_pix_if
// Valid/ready channel carrying one RGB input pixel.
// ----------------------------------------------------------------------------
interface rwm_pix_if;
    import rwm_pkg::*;

    logic valid;
    logic ready;
    t_pix data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rwm_med_if.sv =====
// ----------------------------------------------------------------------------
// rwm_med_if
// Valid/ready channel carrying one median result with its position.
// ----------------------------------------------------------------------------
interface rwm_med_if;
    import rwm_pkg::*;

    logic valid;
    logic ready;
    t_med data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/rwm_line_store.sv =====
// ----------------------------------------------------------------------------
// rwm_line_store
// Line buffer memory: each column holds the pixels of the two previous rows.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module rwm_line_store (
    input  logic            i_clk,
    input  rwm_pkg::t_ls_req i_req,
    output rwm_pkg::t_ls_rd  o_rd
);
    import rwm_pkg::*;

    t_ls_rd r_mem [MAX_WIDTH];
    t_ls_rd r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd = r_rd;

endmodule

// ===== design/rwm_window.sv =====
// ----------------------------------------------------------------------------
// rwm_window
// 3x3 window of pre-sorted columns per channel and the median selection.
// Each column is sorted as it enters; the median is the middle of
// max(lows), middle(mids) and min(highs).
// ----------------------------------------------------------------------------
module rwm_window (
    input  logic           i_clk,
    input  logic           i_shift,
    input  rwm_pkg::t_pix   i_cur,
    input  rwm_pkg::t_ls_rd i_above,
    output rwm_pkg::t_pix   o_median
);
    import rwm_pkg::*;

    t_chans      cur_ch;
    t_chans      a1_ch;
    t_chans      a2_ch;
    t_col_sorted n_col;
    t_col_sorted r_win [WIN_SIDE];
    t_chans      med_ch;

    assign cur_ch = t_chans'(i_cur);
    assign a1_ch  = t_chans'(i_above.above1);
    assign a2_ch  = t_chans'(i_above.above2);

    // sort the incoming column per channel
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_col[ch] = sort3(cur_ch[ch], a1_ch[ch], a2_ch[ch]);
        end
    end

    // column shift register, newest column at index 0
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win[0] <= n_col;
            for (int k = 1; k < WIN_SIDE; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // median of nine from the sorted columns
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            med_ch[ch] = med3(
                max2(max2(r_win[0][ch].lo, r_win[1][ch].lo), r_win[2][ch].lo),
                med3(r_win[0][ch].mid, r_win[1][ch].mid, r_win[2][ch].mid),
                min2(min2(r_win[0][ch].hi, r_win[1][ch].hi), r_win[2][ch].hi));
        end
    end

    assign o_median = t_pix'(med_ch);

endmodule

// ===== design/rgb_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// rgb_window_median_filter
// 3x3 median filter over an RGB raster stream, each channel on its own.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes pixels in raster order, one item per clock when o_med flows.
//   o_med gives one item per interior pixel (at least one pixel from every
//   edge), with the medians, the centre row/column and a frame_last flag on
//   the final interior pixel of the frame. Border pixels give no item.
//   The result for centre (r, c) leaves after pixel (r+1, c+1) is taken:
//   that pixel passes stage 1, stage 2 and the result register to o_med.
//   Throughput is one pixel per cycle when o_med flows; the line store read
//   at accept and written back as stage 1 advances sets the two-stage front end.
//   Widths out of range are clamped to 1..1024; images under 3x3 give nothing.
//   Writing i_cfg_* restarts the frame at row 0, column 0 (write while idle).
//   Reset: counters cleared, width 640, height 480, pipeline empty; the line
//   store needs no clearing since each frame fills rows before reading them.
//   Stall: o_med holds its item while ready is low; i_pix.ready drops once
//   the result register and both stages hold items and o_med.ready is low,
//   and border pixels keep flowing while the window stage is empty.
// ----------------------------------------------------------------------------
module rgb_window_median_filter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    rwm_pix_if.sink                     i_pix,
    rwm_med_if.source                   o_med,
    input  logic                        i_cfg_we,
    input  rwm_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [rwm_pkg::CFG_W-1:0]   i_cfg_data
);
    import rwm_pkg::*;

    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;

    logic             out_free;
    logic             s2_free;
    logic             s1_adv;
    logic             in_ready;
    logic             accept;
    logic             emit;
    t_tag             tag;

    logic             r_s1_valid;
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_col;
    logic             r_s1_emit;
    t_tag             r_s1_tag;

    logic             r_s2_valid;
    t_tag             r_s2_tag;

    logic             r_o_valid;
    t_med             r_o_data;
    t_med             n_o_data;

    t_ls_req          ls_req;
    t_ls_rd           ls_rd;
    t_pix             median;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    // clamp image size to the supported range
    always_comb begin
        priority if (r_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (r_width > CFG_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        priority if (r_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (r_height > CFG_W'(MAX_HEIGHT)) begin
            h_eff = CFG_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
    end

    // pipeline flow control
    assign out_free    = !r_o_valid || o_med.ready;
    assign s2_free     = !r_s2_valid || out_free;
    assign s1_adv      = r_s1_valid && s2_free;
    assign in_ready    = !r_s1_valid || s2_free;
    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    // raster position of the next pixel
    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if ((CFG_W'(r_col) + CFG_W'(1)) >= w_eff) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
            if ((CFG_W'(r_row) + CFG_W'(1)) >= h_eff) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // interior test and centre position
    assign emit = (r_row >= ROW_W'(2 * RADIUS)) && (r_col >= COL_W'(2 * RADIUS));
    assign tag.out_row    = r_row - ROW_W'(RADIUS);
    assign tag.out_col    = r_col - COL_W'(RADIUS);
    assign tag.frame_last = (CFG_W'(r_row) == h_eff - CFG_W'(1))
                         && (CFG_W'(r_col) == w_eff - CFG_W'(1));

    // stage 1: accepted pixel, line store read in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix  <= i_pix.data;
            r_s1_col  <= r_col;
            r_s1_emit <= emit;
            r_s1_tag  <= tag;
        end
    end

    // line store: read at accept, write back the shifted column as stage 1 advances
    assign ls_req.rd_en          = accept;
    assign ls_req.rd_addr        = r_col;
    assign ls_req.wr_en          = s1_adv;
    assign ls_req.wr_addr        = r_s1_col;
    assign ls_req.wr_data.above1 = r_s1_pix;
    assign ls_req.wr_data.above2 = ls_rd.above1;

    rwm_line_store u_line_store (
        .i_clk (i_clk),
        .i_req (ls_req),
        .o_rd  (ls_rd)
    );

    rwm_window u_window (
        .i_clk    (i_clk),
        .i_shift  (s1_adv),
        .i_cur    (r_s1_pix),
        .i_above  (ls_rd),
        .o_median (median)
    );

    // stage 2: window holds the item's neighborhood
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_free) begin
            r_s2_valid <= s1_adv && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_tag <= r_s1_tag;
        end
    end

    // result register
    always_comb begin
        n_o_data.red_median   = median.red_in;
        n_o_data.green_median = median.green_in;
        n_o_data.blue_median  = median.blue_in;
        n_o_data.out_row      = r_s2_tag.out_row;
        n_o_data.out_col      = r_s2_tag.out_col;
        n_o_data.frame_last   = r_s2_tag.frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s2_valid) begin
            r_o_data <= n_o_data;
        end
    end

    assign o_med.valid = r_o_valid;
    assign o_med.data  = r_o_data;

`ifndef SYNTHESIS
    // column counter stays inside the clamped width
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CFG_W'(r_col) < w_eff)
        else $error("column counter beyond image width");

    // row counter stays inside the clamped height
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CFG_W'(r_row) < h_eff)
        else $error("row counter beyond image height");

    // a result centre is never on the top or left border
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_data.out_row >= ROW_W'(RADIUS))
                   && (r_o_data.out_col >= COL_W'(RADIUS)))
        else $error("result centre on the image border");

    // a blocked window stage keeps its item and position
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !out_free) |=> (r_s2_valid && $stable(r_s2_tag)))
        else $error("window stage lost its item under stall");
`endif

endmodule
